/* design/wwf_pkg.sv */
// Shared types and codes for the weighted water-fill allocator.
// No dependencies; wwf_scale_div and the allocator top level import this package.
package wwf_pkg;

   localparam int RATE_W   = 40;
   localparam int ID_W     = 16;
   localparam int WEIGHT_W = 28;
   localparam int STATUS_W = 3;

   // Command codes
   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_ALLOC  = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_WEIGHT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO_MAX   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MIN_OVER   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;
   localparam logic [STATUS_W-1:0] ST_NO_ALLOC   = 3'd6;

   localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

   typedef struct packed {
      logic [1:0]          cmd;
      logic [ID_W-1:0]     flow_id;
      logic [WEIGHT_W-1:0] weight;
      logic [RATE_W-1:0]   min_rate;
      logic [RATE_W-1:0]   max_rate;
      logic                has_max;
      logic [RATE_W-1:0]   total_rate;
      logic                estimate_ok;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]     out_flow;
      logic [RATE_W-1:0]   target_rate;
      logic [STATUS_W-1:0] status;
      logic                last;
   } rsp_type;

   // One row of the flow table
   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [WEIGHT_W-1:0] weight;
      logic [RATE_W-1:0]   min_rate;
      logic [RATE_W-1:0]   max_rate;
      logic                limited;
   } entry_type;

   // Per-flow working state of an allocation
   typedef struct packed {
      logic [RATE_W-1:0] target;
      logic              open;
   } work_type;

endpackage

/* design/wwf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wwf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* design/wwf_scale_div.sv */
// Multi-cycle unit computing floor(a * b / c) for b <= c.
// Depends on wwf_pkg. Two partial products, one add, then one quotient bit per cycle.
module wwf_scale_div
   import wwf_pkg::*;
#(
   parameter int SUM_W = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [RATE_W-1:0]   a,
   input  logic [WEIGHT_W-1:0] b,
   input  logic [SUM_W-1:0]    c,
   output logic                done,
   output logic [RATE_W-1:0]   quotient
);

   localparam int HALF_W = RATE_W / 2;
   localparam int PP_W   = HALF_W + WEIGHT_W;
   localparam int PROD_W = RATE_W + WEIGHT_W;
   localparam int CNT_W  = $clog2(PROD_W + 1);

   localparam logic [2:0] P_IDLE = 3'd0;
   localparam logic [2:0] P_LO   = 3'd1;
   localparam logic [2:0] P_HI   = 3'd2;
   localparam logic [2:0] P_ADD  = 3'd3;
   localparam logic [2:0] P_DIV  = 3'd4;

   logic [2:0]          phase_ff, phase_in;
   logic [RATE_W-1:0]   a_ff, a_in;
   logic [WEIGHT_W-1:0] b_ff, b_in;
   logic [SUM_W-1:0]    c_ff, c_in;
   logic [PP_W-1:0]     plo_ff, plo_in;
   logic [PP_W-1:0]     phi_ff, phi_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [SUM_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic [SUM_W:0]      shifted;
   logic                take;

   // Sequence multiply, add and restoring division
   always_comb begin
      phase_in = phase_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      shifted  = {rem_ff, prod_ff[PROD_W-1]};
      take     = (shifted >= {1'b0, c_ff});
      unique case (phase_ff)
         P_IDLE: begin
            if (start) begin
               a_in     = a;
               b_in     = b;
               c_in     = c;
               phase_in = P_LO;
            end
         end
         P_LO: begin
            plo_in   = PP_W'(a_ff[HALF_W-1:0]) * PP_W'(b_ff);
            phase_in = P_HI;
         end
         P_HI: begin
            phi_in   = PP_W'(a_ff[RATE_W-1:HALF_W]) * PP_W'(b_ff);
            phase_in = P_ADD;
         end
         P_ADD: begin
            prod_in  = (PROD_W'(phi_ff) << HALF_W) + PROD_W'(plo_ff);
            rem_in   = '0;
            cnt_in   = '0;
            phase_in = P_DIV;
         end
         P_DIV: begin
            if (take) begin
               rem_in = SUM_W'(shifted - {1'b0, c_ff});
            end else begin
               rem_in = shifted[SUM_W-1:0];
            end
            prod_in = {prod_ff[PROD_W-2:0], take};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(PROD_W - 1)) begin
               done_in  = 1'b1;
               phase_in = P_IDLE;
            end
         end
         default: phase_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = prod_ff[RATE_W-1:0];

endmodule

/* design/weighted_water_fill_allocator.sv */
// Weighted max-min fair rate allocator: top level with flow table sequencer.
// Depends on wwf_pkg, wwf_ram and wwf_scale_div.
//
// Usage: req_* is a valid/ready channel carrying one command per beat (add flow,
// remove flow, allocate). rsp_* is a valid/ready channel carrying result beats;
// last marks the final beat of a command. An allocate returns one beat per flow
// in ascending id order, or a single beat when refused; every other command
// returns a single beat, and the unused command code returns nothing.
// Commands are taken one at a time: req_ready is high only while the sequencer
// is idle. The flow table and the per-flow working state sit in two RAMs with
// registered read data, and every pass walks all MAX_FLOWS rows, reading a row
// and then processing it. An allocate takes an init pass, then per round a
// weight-sum pass plus a capping pass in which every limited open flow uses the
// shared divider, then a share pass, and output ordering with one ordering scan
// of the table per result.
// Reset empties the table at once; no clearing pass is needed.
// When the receiver stalls, the result register holds its beat and the
// sequencer waits before loading the next one.
module weighted_water_fill_allocator
   import wwf_pkg::*;
#(
   parameter int MAX_FLOWS        = 16,
   parameter int WEIGHT_FRAC_BITS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W  = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
   localparam int CNT_W  = $clog2(MAX_FLOWS + 1);
   localparam int SUM_W  = WEIGHT_W + IDX_W;
   localparam int SMIN_W = RATE_W + IDX_W;
   localparam int ENT_W  = $bits(entry_type);
   localparam int WRK_W  = $bits(work_type);
   localparam logic [36:0] WEIGHT_LIMIT = 37'(1000000) << WEIGHT_FRAC_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_FLOWS - 1);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_ADD_RD   = 5'd1;
   localparam logic [4:0] S_ADD_PR   = 5'd2;
   localparam logic [4:0] S_ADD_FIN  = 5'd3;
   localparam logic [4:0] S_REM_RD   = 5'd4;
   localparam logic [4:0] S_REM_PR   = 5'd5;
   localparam logic [4:0] S_RESP     = 5'd6;
   localparam logic [4:0] S_INIT_RD  = 5'd7;
   localparam logic [4:0] S_INIT_PR  = 5'd8;
   localparam logic [4:0] S_SETUP    = 5'd9;
   localparam logic [4:0] S_ROUND    = 5'd10;
   localparam logic [4:0] S_SUM_RD   = 5'd11;
   localparam logic [4:0] S_SUM_PR   = 5'd12;
   localparam logic [4:0] S_CAP_RD   = 5'd13;
   localparam logic [4:0] S_CAP_PR   = 5'd14;
   localparam logic [4:0] S_CAP_WAIT = 5'd15;
   localparam logic [4:0] S_DST_RD   = 5'd16;
   localparam logic [4:0] S_DST_PR   = 5'd17;
   localparam logic [4:0] S_DST_WAIT = 5'd18;
   localparam logic [4:0] S_ORD_RD   = 5'd19;
   localparam logic [4:0] S_ORD_PR   = 5'd20;
   localparam logic [4:0] S_OUT_RD   = 5'd21;
   localparam logic [4:0] S_OUT_PR   = 5'd22;

   logic [4:0]          state_ff, state_in;
   req_type             req_ff, req_in;
   logic [IDX_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [MAX_FLOWS-1:0] used_ff, used_in;
   logic [MAX_FLOWS-1:0] done_ff, done_in;
   logic                dup_ff, dup_in;
   logic [SMIN_W-1:0]   summin_ff, summin_in;
   logic [RATE_W-1:0]   remaining_ff, remaining_in;
   logic [SUM_W-1:0]    wsum_ff, wsum_in;
   logic                capped_ff, capped_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic                best_valid_ff, best_valid_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [ID_W-1:0]     best_id_ff, best_id_in;
   logic [ID_W-1:0]     resp_flow_ff, resp_flow_in;
   logic [STATUS_W-1:0] resp_status_ff, resp_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   entry_type           ent_rd, ent_wr;
   work_type            wrk_rd, wrk_wr;
   logic [ENT_W-1:0]    ent_rdata;
   logic [WRK_W-1:0]    wrk_rdata;
   logic                ent_we, wrk_we;
   logic [IDX_W-1:0]    ent_waddr;
   logic                div_start, div_done;
   logic [RATE_W-1:0]   div_q;
   logic                free_found;
   logic [IDX_W-1:0]    free_idx;
   logic                can_emit;
   logic                row_used;
   logic                last_row;
   logic [STATUS_W-1:0] pre_status;
   logic [RATE_W:0]     grown;
   logic                cand;

   assign ent_rd = entry_type'(ent_rdata);
   assign wrk_rd = work_type'(wrk_rdata);

   // Flow table and working state memories
   wwf_ram #(.WIDTH(ENT_W), .DEPTH(MAX_FLOWS)) u_entry_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_wr),
      .raddr (scan_idx_ff),
      .rdata (ent_rdata)
   );

   wwf_ram #(.WIDTH(WRK_W), .DEPTH(MAX_FLOWS)) u_work_ram (
      .clock (clock),
      .we    (wrk_we),
      .waddr (scan_idx_ff),
      .wdata (wrk_wr),
      .raddr (scan_idx_ff),
      .rdata (wrk_rdata)
   );

   // Shared multiply and divide for share computation
   wwf_scale_div #(.SUM_W(SUM_W)) u_scale_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .a        (remaining_ff),
      .b        (ent_rd.weight),
      .c        (wsum_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Find the lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = MAX_FLOWS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // Field checks of an add, in priority order
   always_comb begin
      if (req_ff.weight == '0 || 37'(req_ff.weight) > WEIGHT_LIMIT) begin
         pre_status = ST_BAD_WEIGHT;
      end else if (req_ff.has_max && req_ff.max_rate == '0) begin
         pre_status = ST_ZERO_MAX;
      end else if (req_ff.has_max && req_ff.min_rate > req_ff.max_rate) begin
         pre_status = ST_MIN_OVER;
      end else begin
         pre_status = ST_OK;
      end
   end

   assign can_emit = !rsp_valid_ff || rsp_ready;
   assign row_used = used_ff[scan_idx_ff];
   assign last_row = (scan_idx_ff == LAST_IDX);
   assign grown    = {1'b0, wrk_rd.target} + {1'b0, div_q};

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      scan_idx_in    = scan_idx_ff;
      used_in        = used_ff;
      done_in        = done_ff;
      dup_in         = dup_ff;
      summin_in      = summin_ff;
      remaining_in   = remaining_ff;
      wsum_in        = wsum_ff;
      capped_in      = capped_ff;
      left_in        = left_ff;
      best_valid_in  = best_valid_ff;
      best_idx_in    = best_idx_ff;
      best_id_in     = best_id_ff;
      resp_flow_in   = resp_flow_ff;
      resp_status_in = resp_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      ent_we         = 1'b0;
      ent_waddr      = free_idx;
      ent_wr.id       = req_ff.flow_id;
      ent_wr.weight   = req_ff.weight;
      ent_wr.min_rate = req_ff.min_rate;
      ent_wr.max_rate = req_ff.has_max ? req_ff.max_rate : '0;
      ent_wr.limited  = req_ff.has_max;
      wrk_we         = 1'b0;
      wrk_wr         = wrk_rd;
      div_start      = 1'b0;
      cand           = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               scan_idx_in = '0;
               dup_in      = 1'b0;
               unique case (req_data.cmd)
                  CMD_ADD:    state_in = S_ADD_RD;
                  CMD_REMOVE: state_in = S_REM_RD;
                  CMD_ALLOC: begin
                     if (!req_data.estimate_ok || used_ff == '0) begin
                        resp_flow_in   = '0;
                        resp_status_in = ST_NO_ALLOC;
                        state_in       = S_RESP;
                     end else begin
                        summin_in = '0;
                        left_in   = '0;
                        done_in   = '0;
                        state_in  = S_INIT_RD;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         // Duplicate id scan
         S_ADD_RD: state_in = S_ADD_PR;
         S_ADD_PR: begin
            if (row_used && ent_rd.id == req_ff.flow_id) begin
               dup_in = 1'b1;
            end
            if (last_row) begin
               state_in = S_ADD_FIN;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
               state_in    = S_ADD_RD;
            end
         end
         S_ADD_FIN: begin
            resp_flow_in = req_ff.flow_id;
            if (pre_status != ST_OK) begin
               resp_status_in = pre_status;
            end else if (dup_ff) begin
               resp_status_in = ST_DUPLICATE;
            end else if (!free_found) begin
               resp_status_in = ST_FULL;
            end else begin
               resp_status_in     = ST_OK;
               ent_we             = 1'b1;
               used_in[free_idx]  = 1'b1;
            end
            state_in = S_RESP;
         end

         // Remove scan
         S_REM_RD: state_in = S_REM_PR;
         S_REM_PR: begin
            if (row_used && ent_rd.id == req_ff.flow_id) begin
               used_in[scan_idx_ff] = 1'b0;
            end
            if (last_row) begin
               resp_flow_in   = req_ff.flow_id;
               resp_status_in = ST_OK;
               state_in       = S_RESP;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
               state_in    = S_REM_RD;
            end
         end

         // Single-beat result
         S_RESP: begin
            if (can_emit) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.out_flow    = resp_flow_ff;
               rsp_data_in.target_rate = '0;
               rsp_data_in.status      = resp_status_ff;
               rsp_data_in.last        = 1'b1;
               state_in                = S_IDLE;
            end
         end

         // Start every flow at its minimum
         S_INIT_RD: state_in = S_INIT_PR;
         S_INIT_PR: begin
            if (row_used) begin
               wrk_we        = 1'b1;
               wrk_wr.target = ent_rd.min_rate;
               wrk_wr.open   = !ent_rd.limited || ent_rd.max_rate > ent_rd.min_rate;
               summin_in     = summin_ff + SMIN_W'(ent_rd.min_rate);
               left_in       = left_ff + CNT_W'(1);
            end
            if (last_row) begin
               state_in = S_SETUP;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
               state_in    = S_INIT_RD;
            end
         end
         S_SETUP: begin
            if (SMIN_W'(req_ff.total_rate) > summin_ff) begin
               remaining_in = RATE_W'(SMIN_W'(req_ff.total_rate) - summin_ff);
            end else begin
               remaining_in = '0;
            end
            state_in = S_ROUND;
         end
         S_ROUND: begin
            scan_idx_in = '0;
            if (remaining_ff == '0) begin
               best_valid_in = 1'b0;
               state_in      = S_ORD_RD;
            end else begin
               wsum_in  = '0;
               state_in = S_SUM_RD;
            end
         end

         // Sum the open weights
         S_SUM_RD: state_in = S_SUM_PR;
         S_SUM_PR: begin
            if (row_used && wrk_rd.open) begin
               wsum_in = wsum_ff + SUM_W'(ent_rd.weight);
            end
            if (last_row) begin
               scan_idx_in = '0;
               if (wsum_in == '0) begin
                  best_valid_in = 1'b0;
                  state_in      = S_ORD_RD;
               end else begin
                  capped_in = 1'b0;
                  state_in  = S_CAP_RD;
               end
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
               state_in    = S_SUM_RD;
            end
         end

         // Cap limited flows whose share reaches their maximum
         S_CAP_RD: state_in = S_CAP_PR;
         S_CAP_PR, S_CAP_WAIT: begin
            if (state_ff == S_CAP_PR && row_used && wrk_rd.open && ent_rd.limited) begin
               div_start = 1'b1;
               state_in  = S_CAP_WAIT;
            end else if (state_ff == S_CAP_PR || div_done) begin
               if (state_ff == S_CAP_WAIT && grown >= {1'b0, ent_rd.max_rate}) begin
                  remaining_in  = remaining_ff - (ent_rd.max_rate - wrk_rd.target);
                  wrk_we        = 1'b1;
                  wrk_wr.target = ent_rd.max_rate;
                  wrk_wr.open   = 1'b0;
                  capped_in     = 1'b1;
               end
               if (last_row) begin
                  if (capped_in) begin
                     state_in = S_ROUND;
                  end else begin
                     scan_idx_in = '0;
                     state_in    = S_DST_RD;
                  end
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
                  state_in    = S_CAP_RD;
               end
            end
         end

         // Hand out the remainder by weight
         S_DST_RD: state_in = S_DST_PR;
         S_DST_PR, S_DST_WAIT: begin
            if (state_ff == S_DST_PR && row_used && wrk_rd.open) begin
               div_start = 1'b1;
               state_in  = S_DST_WAIT;
            end else if (state_ff == S_DST_PR || div_done) begin
               if (state_ff == S_DST_WAIT) begin
                  wrk_we        = 1'b1;
                  wrk_wr.target = grown[RATE_W] ? RATE_MAX : grown[RATE_W-1:0];
               end
               if (last_row) begin
                  scan_idx_in   = '0;
                  best_valid_in = 1'b0;
                  state_in      = S_ORD_RD;
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
                  state_in    = S_DST_RD;
               end
            end
         end

         // Find the smallest id not yet sent
         S_ORD_RD: state_in = S_ORD_PR;
         S_ORD_PR: begin
            cand = row_used && !done_ff[scan_idx_ff] &&
                   (!best_valid_ff || ent_rd.id < best_id_ff);
            if (cand) begin
               best_valid_in = 1'b1;
               best_idx_in   = scan_idx_ff;
               best_id_in    = ent_rd.id;
            end
            if (last_row) begin
               if (best_valid_in) begin
                  scan_idx_in = best_idx_in;
                  state_in    = S_OUT_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
               state_in    = S_ORD_RD;
            end
         end
         S_OUT_RD: state_in = S_OUT_PR;
         S_OUT_PR: begin
            if (can_emit) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.out_flow    = best_id_ff;
               rsp_data_in.target_rate = wrk_rd.target;
               rsp_data_in.status      = ST_OK;
               rsp_data_in.last        = (left_ff == CNT_W'(1));
               done_in[best_idx_ff]    = 1'b1;
               left_in                 = left_ff - CNT_W'(1);
               if (left_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  scan_idx_in   = '0;
                  best_valid_in = 1'b0;
                  state_in      = S_ORD_RD;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff         <= req_in;
      scan_idx_ff    <= scan_idx_in;
      done_ff        <= done_in;
      dup_ff         <= dup_in;
      summin_ff      <= summin_in;
      remaining_ff   <= remaining_in;
      wsum_ff        <= wsum_in;
      capped_ff      <= capped_in;
      left_ff        <= left_in;
      best_valid_ff  <= best_valid_in;
      best_idx_ff    <= best_idx_in;
      best_id_ff     <= best_id_in;
      resp_flow_ff   <= resp_flow_in;
      resp_status_ff <= resp_status_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/weighted_water_fill_allocator_test.sv */
// Self-checking testbench for weighted_water_fill_allocator: flow table edits and
// weighted max-min allocation, predicted in-line and checked beat by beat.
// Depends on wwf_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module weighted_water_fill_allocator_test;
   import wwf_pkg::*;

   localparam int FLOWS        = 16;
   localparam int FRAC_BITS    = 8;
   localparam longint W_LIMIT  = 64'd1000000 << FRAC_BITS;
   localparam longint CYCLE_CAP = 40000000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Predicted flow table
   bit                  flow_used [FLOWS];
   logic [ID_W-1:0]     flow_id   [FLOWS];
   logic [63:0]         flow_wgt  [FLOWS];
   logic [63:0]         flow_min  [FLOWS];
   logic [63:0]         flow_max  [FLOWS];
   bit                  flow_lim  [FLOWS];

   rsp_type target_q[$];
   int      errors = 0;
   longint  cycles = 0;
   bit      steady = 1'b0;
   bit      hold_start = 1'b0;
   int      hold_len = 0;

   weighted_water_fill_allocator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // floor(a * b / c) without overflow, b <= c
   function automatic logic [63:0] weighted_share(logic [63:0] a, logic [63:0] b,
                                                  logic [63:0] c);
      if (c == 64'd0) return 64'd0;
      return (a / c) * b + ((a % c) * b) / c;
   endfunction

   function automatic logic [RATE_W-1:0] rand_rate();
      logic [63:0] v;
      v = {$urandom, $urandom};
      v = 64'(v[RATE_W-1:0]) >> $urandom_range(0, RATE_W - 1);
      return v[RATE_W-1:0];
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (steady || p < 45) return 0;
      if (p < 75) return $urandom_range(1, 2);
      if (p < 95) return $urandom_range(3, 10);
      return $urandom_range(20, 80);
   endfunction

   // Append one expected beat
   task automatic queue_expect(rsp_type r);
      target_q.insert(target_q.size(), r);
   endtask

   // Water-fill the table and queue one target per flow in id order
   task automatic predict_allocation(logic [63:0] total);
      logic [63:0] tgt [FLOWS];
      bit          open [FLOWS];
      bit          done [FLOWS];
      logic [63:0] summin, remaining, wsum, share;
      int          count, best;
      bit          capped;
      rsp_type     r;
      summin = 0;
      count = 0;
      for (int i = 0; i < FLOWS; i++) begin
         done[i] = 0;
         open[i] = 0;
         tgt[i] = 0;
         if (flow_used[i]) begin
            count++;
            tgt[i] = flow_min[i];
            summin += flow_min[i];
            open[i] = !flow_lim[i] || flow_max[i] > flow_min[i];
         end
      end
      remaining = (total > summin) ? total - summin : 64'd0;
      while (remaining > 0) begin
         wsum = 0;
         for (int i = 0; i < FLOWS; i++)
            if (flow_used[i] && open[i]) wsum += flow_wgt[i];
         if (wsum == 0) break;
         capped = 0;
         // fix flows that reach their maximum, then share again
         for (int i = 0; i < FLOWS; i++) begin
            if (!flow_used[i] || !open[i] || !flow_lim[i]) continue;
            share = weighted_share(remaining, flow_wgt[i], wsum);
            if (tgt[i] + share >= flow_max[i]) begin
               remaining -= flow_max[i] - tgt[i];
               tgt[i] = flow_max[i];
               open[i] = 0;
               capped = 1;
            end
         end
         if (capped) continue;
         for (int i = 0; i < FLOWS; i++) begin
            if (flow_used[i] && open[i]) begin
               tgt[i] += weighted_share(remaining, flow_wgt[i], wsum);
               if (tgt[i] > 64'(RATE_MAX)) tgt[i] = 64'(RATE_MAX);
            end
         end
         break;
      end
      for (int k = 0; k < count; k++) begin
         best = -1;
         for (int i = 0; i < FLOWS; i++)
            if (flow_used[i] && !done[i] && (best < 0 || flow_id[i] < flow_id[best]))
               best = i;
         done[best] = 1;
         r.out_flow    = flow_id[best];
         r.target_rate = tgt[best][RATE_W-1:0];
         r.status      = ST_OK;
         r.last        = (k == count - 1);
         queue_expect(r);
      end
   endtask

   // Apply one accepted command to the predicted table
   task automatic predict_command(req_type c);
      rsp_type r;
      int      slot;
      bit      any;
      r.out_flow = c.flow_id;
      r.target_rate = '0;
      r.status = ST_OK;
      r.last = 1'b1;
      case (c.cmd)
         CMD_ADD: begin
            if (c.weight == 0 || 64'(c.weight) > W_LIMIT) r.status = ST_BAD_WEIGHT;
            else if (c.has_max && c.max_rate == 0) r.status = ST_ZERO_MAX;
            else if (c.has_max && c.min_rate > c.max_rate) r.status = ST_MIN_OVER;
            if (r.status == ST_OK)
               for (int i = 0; i < FLOWS; i++)
                  if (flow_used[i] && flow_id[i] == c.flow_id) r.status = ST_DUPLICATE;
            slot = -1;
            if (r.status == ST_OK) begin
               for (int i = FLOWS - 1; i >= 0; i--)
                  if (!flow_used[i]) slot = i;
               if (slot < 0) r.status = ST_FULL;
            end
            if (r.status == ST_OK) begin
               flow_used[slot] = 1;
               flow_id[slot]   = c.flow_id;
               flow_wgt[slot]  = 64'(c.weight);
               flow_min[slot]  = 64'(c.min_rate);
               flow_max[slot]  = c.has_max ? 64'(c.max_rate) : 64'd0;
               flow_lim[slot]  = c.has_max;
            end
            queue_expect(r);
         end
         CMD_REMOVE: begin
            for (int i = 0; i < FLOWS; i++)
               if (flow_used[i] && flow_id[i] == c.flow_id) flow_used[i] = 0;
            queue_expect(r);
         end
         CMD_ALLOC: begin
            any = 0;
            for (int i = 0; i < FLOWS; i++) any |= flow_used[i];
            if (!c.estimate_ok || !any) begin
               r.out_flow = '0;
               r.status = ST_NO_ALLOC;
               queue_expect(r);
            end else
               predict_allocation(64'(c.total_rate));
         end
         default: ;
      endcase
   endtask

   // Offer one command beat and hold it until accepted
   task automatic send_command(req_type c);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= c;
      do @(posedge clock); while (!req_ready);
      predict_command(c);
   endtask

   function automatic req_type make_add(logic [ID_W-1:0] id, logic [WEIGHT_W-1:0] w,
                                        logic [RATE_W-1:0] mn, logic [RATE_W-1:0] mx,
                                        logic hm);
      req_type c;
      c = '0;
      c.cmd = CMD_ADD;
      c.flow_id = id;
      c.weight = w;
      c.min_rate = mn;
      c.max_rate = mx;
      c.has_max = hm;
      return c;
   endfunction

   function automatic req_type make_cmd(logic [1:0] cmd, logic [ID_W-1:0] id,
                                        logic [RATE_W-1:0] total, logic ok);
      req_type c;
      c = '0;
      c.cmd = cmd;
      c.flow_id = id;
      c.total_rate = total;
      c.estimate_ok = ok;
      return c;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // Check each result beat against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (target_q.size() == 0)
            report_mismatch("unexpected beat flow", rsp_data.out_flow, -1);
         else begin
            want = target_q.pop_front();
            if (rsp_data.out_flow != want.out_flow)
               report_mismatch("out_flow", rsp_data.out_flow, want.out_flow);
            if (rsp_data.target_rate != want.target_rate)
               report_mismatch("target_rate", rsp_data.target_rate, want.target_rate);
            if (rsp_data.status != want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.last != want.last)
               report_mismatch("last", rsp_data.last, want.last);
         end
      end
   end

   // Drive rsp_ready: random stalls, steady stretches, long hold-off on request
   always @(posedge clock) begin
      int p;
      if (hold_start) begin
         hold_start = 1'b0;
         hold_len = 3000;
      end
      if (hold_len > 0) begin
         hold_len--;
         rsp_ready <= 1'b0;
      end else if (steady) begin
         rsp_ready <= 1'b1;
      end else begin
         p = $urandom_range(0, 99);
         if (p < 97 && !rsp_ready) rsp_ready <= ($urandom_range(0, 3) != 0);
         else if (p < 70) rsp_ready <= 1'b1;
         else if (p < 97) rsp_ready <= 1'b0;
         else begin
            rsp_ready <= 1'b0;
            hold_len = $urandom_range(20, 120);
         end
      end
   end

   // Error checks, empty-table and invalid-estimate allocation, table full
   task automatic test_directed();
      send_command(make_cmd(CMD_ALLOC, 16'd0, RATE_MAX, 1'b1));
      send_command(make_add(16'hFFFF, 28'd0, '0, '0, 1'b0));
      send_command(make_add(16'd1, WEIGHT_W'(W_LIMIT + 1), '0, '0, 1'b0));
      send_command(make_add(16'd2, 28'hFFFFFFF, '0, '0, 1'b0));
      send_command(make_add(16'd3, 28'd256, 40'd5, 40'd0, 1'b1));
      send_command(make_add(16'd4, 28'd256, 40'd6, 40'd5, 1'b1));
      send_command(make_add(16'hFFFF, WEIGHT_W'(W_LIMIT), RATE_MAX, RATE_MAX, 1'b1));
      send_command(make_add(16'd0, 28'd1, 40'd0, 40'd1, 1'b1));
      send_command(make_add(16'd0, 28'd9, 40'd0, 40'd0, 1'b0));
      send_command(make_cmd(CMD_ALLOC, 16'd0, RATE_MAX, 1'b0));
      send_command(make_cmd(CMD_UNUSED, 16'hFFFF, RATE_MAX, 1'b1));
      send_command(make_cmd(CMD_REMOVE, 16'd777, '0, 1'b0));
      // minimums above the total: no sharing
      send_command(make_cmd(CMD_ALLOC, 16'd0, 40'd10, 1'b1));
      send_command(make_add(16'd9, 28'd100, 40'd1000, 40'd0, 1'b0));
      send_command(make_add(16'd7, 28'd300, 40'd10, 40'd2000, 1'b1));
      send_command(make_cmd(CMD_ALLOC, 16'd0, 40'd100000, 1'b1));
      send_command(make_cmd(CMD_ALLOC, 16'd0, RATE_MAX, 1'b1));
      send_command(make_cmd(CMD_ALLOC, 16'd0, '0, 1'b1));
      // fill the table, then one more
      for (int i = 0; i < 12; i++)
         send_command(make_add(ID_W'(100 + i), WEIGHT_W'(256 * (i + 1)),
                               40'd0, 40'd0, 1'b0));
      send_command(make_add(16'd500, 28'd256, 40'd0, 40'd0, 1'b0));
      send_command(make_cmd(CMD_ALLOC, 16'd0, 40'd123456789, 1'b1));
      send_command(make_cmd(CMD_REMOVE, 16'hFFFF, '0, 1'b0));
      send_command(make_cmd(CMD_REMOVE, 16'd0, '0, 1'b0));
   endtask

   function automatic logic [ID_W-1:0] pick_id();
      int n;
      if ($urandom_range(0, 99) < 65) return ID_W'($urandom_range(0, 31));
      n = $urandom;
      return n[ID_W-1:0];
   endfunction

   function automatic req_type random_command();
      req_type c;
      int      p, n;
      logic [RATE_W-1:0] a, b;
      logic [191:0] noise;
      p = $urandom_range(0, 99);
      if (p < 8) begin
         // noise: every field random
         noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         c = noise[$bits(req_type)-1:0];
         if (c.cmd == CMD_UNUSED && $urandom_range(0, 1)) c.cmd = CMD_ALLOC;
      end else if (p < 48) begin
         a = rand_rate();
         b = rand_rate();
         if ($urandom_range(0, 9) != 0 && a > b) {a, b} = {b, a};
         c = make_add(pick_id(), WEIGHT_W'($urandom_range(1, 32'(W_LIMIT))), a, b,
                      1'($urandom_range(0, 1)));
         if ($urandom_range(0, 4) == 0) c.weight = WEIGHT_W'($urandom_range(1, 4096));
      end else if (p < 70) begin
         c = make_cmd(CMD_REMOVE, pick_id(), '0, 1'b0);
         n = $urandom_range(0, FLOWS - 1);
         if (flow_used[n] && $urandom_range(0, 2) != 0) c.flow_id = flow_id[n];
      end else begin
         c = make_cmd(CMD_ALLOC, '0, rand_rate(), $urandom_range(0, 15) != 0);
      end
      return c;
   endfunction

   task automatic test_random();
      for (int i = 0; i < 220; i++) begin
         if (i % 40 == 0) steady = ($urandom_range(0, 2) == 0);
         send_command(random_command());
      end
      steady = 1'b0;
   endtask

   // Long receiver hold-off while commands keep coming
   task automatic test_backpressure();
      hold_start = 1'b1;
      send_command(make_cmd(CMD_ALLOC, '0, RATE_MAX, 1'b1));
      for (int i = 0; i < 14; i++) send_command(random_command());
   endtask

   initial begin
      int waited;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      test_backpressure();
      req_valid <= 1'b0;
      waited = 0;
      while (target_q.size() != 0 && waited < 2000000) begin
         @(posedge clock);
         waited++;
      end
      repeat (500) @(posedge clock);
      if (errors == 0 && target_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
